[rtl/masked_patch_command_parser_macros.svh]
`ifndef MASKED_PATCH_COMMAND_PARSER_MACROS_SVH
`define MASKED_PATCH_COMMAND_PARSER_MACROS_SVH

// checked only while out of reset
`define MPCP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MPCP_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mpcp_pkg.sv]
`default_nettype none

package mpcp_pkg;

    localparam int POS_W       = 17;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0]  PAD_BYTE      = 8'hAA;
    localparam logic [7:0]  NO_PATCH_BYTE = 8'hFF;
    localparam logic [7:0]  FLAG_ON_BYTE  = 8'h01;
    localparam logic [16:0] POS_BIAS      = 17'd16;
    localparam logic [31:0] LEN_BIAS      = 32'd4;
    localparam logic [31:0] MIN_TOTAL     = 32'd9;
    localparam logic [31:0] UNIT_START    = 32'd8;

    // config register indexes
    localparam logic REG_APP_ID  = 1'b0;
    localparam logic REG_MAX_LEN = 1'b1;

    // result status codes
    localparam logic [1:0] ST_FLAG_OFF = 2'd0;
    localparam logic [1:0] ST_FLAG_ON  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_END_BAD  = 2'd3;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        OP_BUF_WR,
        OP_PATCH,
        OP_STATUS
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  addr;
        logic        addr_oob;
        logic [7:0]  data;
        logic [16:0] pos;
        logic [1:0]  status;
    } cmd_t;

endpackage

`default_nettype wire

[rtl/mpcp_byte_if.sv]
`default_nettype none

interface mpcp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_req;

    modport source (output valid, output data_byte, output start_req, input ready);
    modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

`default_nettype wire

[rtl/mpcp_result_if.sv]
`default_nettype none

interface mpcp_result_if
    import mpcp_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             kind;
    logic [POS_W-1:0] position;
    logic [7:0]       value;
    logic [1:0]       status;

    modport source (output valid, output kind, output position, output value,
                    output status, input ready);
    modport sink   (input valid, input kind, input position, input value,
                    input status, output ready);
endinterface

`default_nettype wire

[rtl/masked_patch_command_parser.sv]
// channel     dir  payload                              handshake
// byte_ch     in   data_byte[7:0], start_req            valid/ready
// result_ch   out  kind, position[16:0], value, status  valid/ready
//
// One byte word accepted per cycle; at most one result word per byte.
// A result goes through the queue stage, then the buffer read register. rst_n is
// asynchronous. The user must write config (app_id, max_total_length) only when
// idle; the block does not enforce it. A 4-entry command queue lets the parser
// keep taking bytes while results stall; byte_ch.ready drops only when it is full.
`default_nettype none

module masked_patch_command_parser
    import mpcp_pkg::*;
#(
    parameter int VALUE_BUFFER_DEPTH = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    mpcp_byte_if.sink        byte_ch,
    mpcp_result_if.source    result_ch,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    logic push, q_full, pop, q_valid;
    cmd_t push_cmd, head;

    mpcp_front #(.VALUE_BUFFER_DEPTH(VALUE_BUFFER_DEPTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .push      (push),
        .cmd       (push_cmd)
    );

    mpcp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head)
    );

    mpcp_back #(.VALUE_BUFFER_DEPTH(VALUE_BUFFER_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .result_ch (result_ch)
    );

endmodule

`default_nettype wire

[rtl/mpcp_front.sv]
`default_nettype none

module mpcp_front
    import mpcp_pkg::*;
#(
    parameter int VALUE_BUFFER_DEPTH = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    mpcp_byte_if.sink        byte_ch,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        q_full,
    output logic             push,
    output cmd_t             cmd
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HEAD = 3'd1;
    localparam logic [2:0] PH_UNIT = 3'd2;
    localparam logic [2:0] PH_FLAG = 3'd3;
    localparam logic [2:0] PH_PEND = 3'd4;

    localparam logic [8:0] DEPTH9 = 9'(VALUE_BUFFER_DEPTH);

    logic [15:0] app_id_reg;
    logic [31:0] max_len_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] tlast_reg, tlast_next;
    logic        hv_reg, hv_next;
    logic [31:0] base_reg, base_next;
    logic [7:0]  rel_reg, rel_next;
    logic [7:0]  size_reg, size_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] first_reg, first_next;
    logic [15:0] last_reg, last_next;
    logic [16:0] m_reg, m_next;
    logic        fwd_reg, fwd_next;

    logic        acc;
    logic [7:0]  b;
    logic [2:0]  phase_c;
    logic [31:0] off_c, total_c;
    logic        hv_c;
    logic [31:0] sh, t4;
    logic        hv_n;
    logic [7:0]  size_c;
    logic [15:0] last_n;
    logic [7:0]  k, j;
    logic        wrote;
    logic [32:0] nxt;

    assign byte_ch.ready = !q_full;
    assign acc = byte_ch.valid && !q_full;
    assign b   = byte_ch.data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            app_id_reg  <= '0;
            max_len_reg <= 32'd2097152;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_APP_ID:  app_id_reg  <= cfg_wdata[15:0];
                REG_MAX_LEN: max_len_reg <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        offset_next = offset_reg;
        total_next  = total_reg;
        tlast_next  = tlast_reg;
        hv_next     = hv_reg;
        base_next   = base_reg;
        rel_next    = rel_reg;
        size_next   = size_reg;
        id_next     = id_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        m_next      = m_reg;
        fwd_next    = fwd_reg;
        push        = 1'b0;
        cmd         = '0;
        phase_c     = byte_ch.start_req ? PH_HEAD : phase_reg;
        off_c       = byte_ch.start_req ? 32'd0 : offset_reg;
        total_c     = byte_ch.start_req ? 32'd0 : total_reg;
        hv_c        = byte_ch.start_req ? 1'b0 : hv_reg;
        sh          = {total_c[23:0], b};
        t4          = sh + LEN_BIAS;
        hv_n        = hv_c || (b != NO_PATCH_BYTE);
        size_c      = (rel_reg == 8'd0) ? b : size_reg;
        last_n      = {last_reg[7:0], b};
        k           = rel_reg - 8'd7;
        j           = k - m_reg[7:0];
        wrote       = 1'b0;
        nxt         = {1'b0, base_reg} + {25'd0, size_c} + 33'd1;

        if (acc)
        begin
            phase_next  = phase_c;
            offset_next = off_c + 32'd1;
            total_next  = total_c;
            hv_next     = hv_c;
            unique case (phase_c)
                PH_IDLE:
                begin
                    offset_next = offset_reg;
                end
                PH_PEND:
                begin
                    push       = 1'b1;
                    cmd.op     = OP_STATUS;
                    cmd.status = ST_END_BAD;
                    phase_next = PH_IDLE;
                end
                PH_HEAD:
                begin
                    if (off_c[31:2] == 30'd0)
                    begin
                        total_next = sh;
                        if (off_c[1:0] == 2'd3)
                        begin
                            total_next = t4;
                            tlast_next = sh + LEN_BIAS - 32'd1;
                            if (t4 > max_len_reg)
                            begin
                                push       = 1'b1;
                                cmd.op     = OP_STATUS;
                                cmd.status = ST_TOO_LONG;
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    else
                    begin
                        hv_next = hv_n;
                        if (off_c[2:0] == 3'd7)
                        begin
                            if (total_c < MIN_TOTAL)
                            begin
                                push       = 1'b1;
                                cmd.op     = OP_STATUS;
                                cmd.status = ST_END_BAD;
                                phase_next = PH_IDLE;
                            end
                            else if (hv_n)
                            begin
                                phase_next = PH_UNIT;
                                base_next  = UNIT_START;
                                rel_next   = 8'd0;
                            end
                            else
                            begin
                                phase_next = PH_FLAG;
                            end
                        end
                    end
                end
                PH_FLAG:
                begin
                    if (off_c == tlast_reg)
                    begin
                        push       = 1'b1;
                        cmd.op     = OP_STATUS;
                        cmd.status = (b == FLAG_ON_BYTE) ? ST_FLAG_ON : ST_FLAG_OFF;
                        phase_next = PH_IDLE;
                    end
                end
                PH_UNIT:
                begin
                    rel_next = rel_reg + 8'd1;
                    if (rel_reg == 8'd0)
                    begin
                        size_next  = b;
                        id_next    = '0;
                        first_next = '0;
                        last_next  = '0;
                    end
                    else if (rel_reg <= 8'd2)
                        id_next = {id_reg[7:0], b};
                    else if (rel_reg <= 8'd4)
                        first_next = {first_reg[7:0], b};
                    else if (rel_reg <= 8'd6)
                    begin
                        last_next = last_n;
                        if (rel_reg == 8'd6)
                        begin
                            fwd_next = last_n >= first_reg;
                            m_next   = {1'b0, last_n} - {1'b0, first_reg} + 17'd1;
                        end
                    end
                    else if (fwd_reg)
                    begin
                        if ({9'd0, k} < m_reg)
                        begin
                            if ({1'b0, k} < DEPTH9)
                            begin
                                push     = 1'b1;
                                cmd.op   = OP_BUF_WR;
                                cmd.addr = k;
                                cmd.data = b;
                            end
                        end
                        else if ({9'd0, j} < m_reg && id_reg == app_id_reg)
                        begin
                            push         = 1'b1;
                            wrote        = 1'b1;
                            cmd.op       = OP_PATCH;
                            cmd.addr     = j;
                            cmd.addr_oob = ({1'b0, j} >= DEPTH9);
                            cmd.data     = b;
                            cmd.pos      = {1'b0, first_reg} + {9'd0, j} + POS_BIAS;
                        end
                    end

                    // lone pad byte closes the unit list
                    if (rel_reg == 8'd0 && b == PAD_BYTE
                        && (tlast_reg - base_reg) < {24'd0, PAD_BYTE})
                    begin
                        if (base_reg + 32'd1 == tlast_reg)
                            phase_next = PH_FLAG;
                        else
                        begin
                            push       = 1'b1;
                            cmd.op     = OP_STATUS;
                            cmd.status = ST_END_BAD;
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (rel_reg == size_c)
                    begin
                        if (nxt < {1'b0, tlast_reg})
                        begin
                            base_next = nxt[31:0];
                            rel_next  = 8'd0;
                        end
                        else if (nxt == {1'b0, tlast_reg})
                            phase_next = PH_FLAG;
                        else if (wrote)
                            phase_next = PH_PEND;
                        else
                        begin
                            push       = 1'b1;
                            cmd        = '0;
                            cmd.op     = OP_STATUS;
                            cmd.status = ST_END_BAD;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            offset_reg <= '0;
            total_reg  <= '0;
            tlast_reg  <= '0;
            hv_reg     <= 1'b0;
            base_reg   <= '0;
            rel_reg    <= '0;
            size_reg   <= '0;
            id_reg     <= '0;
            first_reg  <= '0;
            last_reg   <= '0;
            m_reg      <= '0;
            fwd_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            total_reg  <= total_next;
            tlast_reg  <= tlast_next;
            hv_reg     <= hv_next;
            base_reg   <= base_next;
            rel_reg    <= rel_next;
            size_reg   <= size_next;
            id_reg     <= id_next;
            first_reg  <= first_next;
            last_reg   <= last_next;
            m_reg      <= m_next;
            fwd_reg    <= fwd_next;
        end
    end

endmodule

`default_nettype wire

[rtl/mpcp_queue.sv]
`default_nettype none

module mpcp_queue
    import mpcp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      q_valid,
    output cmd_t      head
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (QPTR_W+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QPTR_W+1)'(1);
        end
    end

endmodule

`default_nettype wire

[rtl/mpcp_back.sv]
`default_nettype none

module mpcp_back
    import mpcp_pkg::*;
#(
    parameter int VALUE_BUFFER_DEPTH = 128
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_valid,
    input  wire cmd_t   head,
    output logic        pop,
    mpcp_result_if.source result_ch
);

    localparam int AW = $clog2(VALUE_BUFFER_DEPTH);

    logic [7:0]       mem [VALUE_BUFFER_DEPTH];
    logic [7:0]       rd_reg;
    logic             valid_reg;
    logic             kind_reg;
    logic [POS_W-1:0] pos_reg;
    logic [7:0]       mask_reg;
    logic [1:0]       status_reg;
    logic             emits;

    assign pop   = q_valid && (!valid_reg || result_ch.ready);
    assign emits = (head.op != OP_BUF_WR);

    always_ff @(posedge clk)
    begin
        if (pop && head.op == OP_BUF_WR)
            mem[head.addr[AW-1:0]] <= head.data;
        if (pop && head.op == OP_PATCH)
            rd_reg <= mem[head.addr[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (pop && emits)
        begin
            kind_reg   <= (head.op == OP_STATUS) ? KIND_STATUS : KIND_WRITE;
            pos_reg    <= head.pos;
            // out-of-range reads and status words carry a zero mask
            mask_reg   <= (head.op == OP_PATCH && !head.addr_oob) ? head.data : 8'd0;
            status_reg <= head.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= emits;
        else if (result_ch.ready)
            valid_reg <= 1'b0;
    end

    assign result_ch.valid    = valid_reg;
    assign result_ch.kind     = kind_reg;
    assign result_ch.position = pos_reg;
    assign result_ch.value    = rd_reg & mask_reg;
    assign result_ch.status   = status_reg;

endmodule

`default_nettype wire

[rtl/mpcp_checker.sv]
`default_nettype none
`include "masked_patch_command_parser_macros.svh"

module mpcp_checker
    import mpcp_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic             kind,
    input wire logic [POS_W-1:0] position,
    input wire logic [7:0]       value,
    input wire logic [1:0]       status
);

    `MPCP_ASSERT_RST(a_hold, out_valid && !out_ready |=> out_valid && $stable(position) && $stable(status), "result word dropped while stalled")
    `MPCP_ASSERT_RST(a_status_clean, out_valid && kind == KIND_STATUS |-> position == '0 && value == 8'd0, "status word carries write payload")
    `MPCP_ASSERT_ANY(a_reset_quiet, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind masked_patch_command_parser mpcp_checker u_mpcp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .kind      (result_ch.kind),
    .position  (result_ch.position),
    .value     (result_ch.value),
    .status    (result_ch.status)
);

`default_nettype wire

[sim/testbench.sv]
`default_nettype none

module testbench;
    import mpcp_pkg::*;

    localparam int BUF_DEPTH  = 128;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 400;

    typedef enum logic [2:0] {PH_IDLE, PH_HEAD, PH_UNIT, PH_FLAG, PH_PEND} phase_t;
    typedef enum int {MSG_GOOD, MSG_NOPATCH, MSG_SHORT, MSG_NOISE, MSG_SKEW, MSG_CUT} msg_t;
    typedef enum int {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_t;

    typedef struct packed {
        logic        kind;
        logic [16:0] position;
        logic [7:0]  value;
        logic [1:0]  status;
    } word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;

    mpcp_byte_if   bch();
    mpcp_result_if rch();

    masked_patch_command_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (bch),
        .result_ch (rch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // parser shadow state
    logic [15:0] app_id_r;
    logic [31:0] max_len_r;
    phase_t      ph;
    logic [31:0] offs, tlen, ubase;
    logic [7:0]  usize;
    logic [15:0] uid, rfirst, rlast;
    logic        hvalid;
    logic [7:0]  vbuf [BUF_DEPTH];

    word_t       patch_q[$];
    gap_t        gap_mode;
    int          errors, n_items, n_writes, n_status, idle_cnt;
    bit          hold_req;
    int          hold_cnt;

    function automatic word_t status_word(input logic [1:0] st);
        word_t r;
        r = '0;
        r.kind = KIND_STATUS;
        r.status = st;
        ph = PH_IDLE;
        return r;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic s, output word_t r);
        logic [31:0] rel, m, k, j;
        logic [32:0] nxt, lst;
        logic [7:0]  v;
        bit          n;
        n = 0;
        r = '0;
        if (s)
        begin
            ph = PH_HEAD;
            offs = 0;
            tlen = 0;
            hvalid = 0;
        end
        if (ph == PH_IDLE)
            return 0;
        if (ph == PH_PEND)
        begin
            r = status_word(ST_END_BAD);
            return 1;
        end
        if (ph == PH_HEAD)
        begin
            if (offs < 4)
            begin
                tlen = {tlen[23:0], b};
                if (offs == 3)
                begin
                    tlen = tlen + LEN_BIAS;
                    if (tlen > max_len_r)
                    begin
                        r = status_word(ST_TOO_LONG);
                        return 1;
                    end
                end
            end
            else
            begin
                if (b != NO_PATCH_BYTE)
                    hvalid = 1;
                if (offs == 7)
                begin
                    if (tlen < MIN_TOTAL)
                    begin
                        r = status_word(ST_END_BAD);
                        return 1;
                    end
                    if (hvalid)
                    begin
                        ph = PH_UNIT;
                        ubase = UNIT_START;
                    end
                    else
                        ph = PH_FLAG;
                end
            end
        end
        else if (ph == PH_FLAG)
        begin
            if (offs == tlen - 1)
            begin
                r = status_word(b == FLAG_ON_BYTE ? ST_FLAG_ON : ST_FLAG_OFF);
                return 1;
            end
        end
        else
        begin
            rel = offs - ubase;
            if (rel == 0)
            begin
                usize = b;
                uid = 0;
                rfirst = 0;
                rlast = 0;
                if (b == PAD_BYTE && (tlen - ubase - 32'd1) < 32'hAA)
                begin
                    if (ubase + 1 == tlen - 1)
                    begin
                        ph = PH_FLAG;
                        offs = offs + 1;
                        return 0;
                    end
                    r = status_word(ST_END_BAD);
                    return 1;
                end
            end
            else if (rel <= 2)
                uid = {uid[7:0], b};
            else if (rel <= 4)
                rfirst = {rfirst[7:0], b};
            else if (rel <= 6)
                rlast = {rlast[7:0], b};
            else if (rlast >= rfirst)
            begin
                m = {16'd0, rlast} - {16'd0, rfirst} + 1;
                k = rel - 7;
                if (k < m)
                begin
                    if (k < BUF_DEPTH)
                        vbuf[k] = b;
                end
                else if (k - m < m && uid == app_id_r)
                begin
                    j = k - m;
                    v = (j < BUF_DEPTH) ? vbuf[j] : 8'd0;
                    r.kind = KIND_WRITE;
                    r.position = 17'({16'd0, rfirst} + j + 32'd16);
                    r.value = v & b;
                    n = 1;
                end
            end
            if (rel == {24'd0, usize})
            begin
                nxt = {1'b0, ubase} + {25'd0, usize} + 33'd1;
                lst = {1'b0, tlen} - 33'd1;
                if (nxt < lst)
                    ubase = nxt[31:0];
                else if (nxt == lst)
                    ph = PH_FLAG;
                else if (n)
                    ph = PH_PEND;
                else
                begin
                    r = status_word(ST_END_BAD);
                    return 1;
                end
            end
        end
        offs = offs + 1;
        return n;
    endfunction

    // ---------------- byte sender
    task automatic send_byte(input logic [7:0] b, input logic s);
        word_t r;
        bch.valid <= 1'b1;
        bch.data_byte <= b;
        bch.start_req <= s;
        do @(posedge clk); while (!bch.ready);
        n_items++;
        if (parse_byte(b, s, r))
            patch_q = {patch_q, r};
        if ((gap_mode == GAP_SEND && $urandom_range(0, 99) < 58) ||
            (gap_mode == GAP_BOTH && $urandom_range(0, 99) < 7))
        begin
            bch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic drain;
        bch.valid <= 1'b0;
        @(posedge clk);
        while (patch_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_APP_ID)
            app_id_r = val[15:0];
        else
            max_len_r = val;
        @(posedge clk);
    endtask

    function automatic logic [7:0] rnd8;
        return 8'($urandom_range(0, 255));
    endfunction

    // builds one message and sends it; big forces one long matching unit
    task automatic send_msg(input msg_t shape, input bit big);
        logic [7:0]  body[$];
        logic [7:0]  cont[$];
        logic [7:0]  valid_b[4];
        logic [31:0] tot, len;
        logic [15:0] first, last, id;
        int          nu, m, real_m, full, u, pad, cut, i;
        body.delete();
        for (i = 0; i < 4; i++)
            valid_b[i] = $urandom_range(0, 1) ? NO_PATCH_BYTE : rnd8();
        if (shape == MSG_NOPATCH)
        begin
            for (i = 0; i < 4; i++)
                valid_b[i] = NO_PATCH_BYTE;
            repeat ($urandom_range(0, 10)) body = {body, rnd8()};
        end
        else if (shape == MSG_NOISE)
        begin
            valid_b[$urandom_range(0, 3)] = rnd8();
            repeat ($urandom_range(0, 30)) body = {body, rnd8()};
        end
        else if (shape != MSG_SHORT)
        begin
            valid_b[$urandom_range(0, 3)] = 8'($urandom_range(0, 254));
            nu = big ? 1 : $urandom_range(1, 3);
            repeat (nu)
            begin
                m = big ? 40 : ($urandom_range(0, 9) == 0 ? $urandom_range(20, 60)
                                                          : $urandom_range(0, 8));
                case ($urandom_range(0, 5))
                    0: first = 16'd0;
                    1: first = 16'hFFFF;
                    default: first = 16'($urandom_range(0, 65535));
                endcase
                if (m == 0)
                begin
                    if (first == 0)
                        first = 1;
                    last = first - 1;
                end
                else
                    last = first + 16'(m - 1);
                real_m = (last >= first) ? int'(last - first) + 1 : 0;
                id = (big || $urandom_range(0, 4) != 0) ? app_id_r
                                                         : 16'($urandom_range(0, 65535));
                cont = '{id[15:8], id[7:0], first[15:8], first[7:0], last[15:8], last[7:0]};
                repeat (2 * real_m) cont = {cont, rnd8()};
                full = cont.size();
                case (big ? 0 : $urandom_range(0, 6))
                    5: u = $urandom_range(0, full);
                    6: u = full + $urandom_range(1, 12);
                    default: u = full;
                endcase
                body = {body, 8'(u)};
                for (i = 0; i < u; i++)
                    body = {body, (i < full) ? cont[i] : rnd8()};
            end
            pad = $urandom_range(0, 1);
            if (pad)
                body = {body, PAD_BYTE};
        end
        if (shape == MSG_SHORT)
        begin
            len = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFC : 32'($urandom_range(0, 4));
        end
        else
        begin
            body = {body, 8'($urandom_range(0, 2))};
            tot = 8 + body.size();
            len = tot - 4;
            if (shape == MSG_SKEW)
                len = len + 32'($urandom_range(0, 6)) - 32'd3;
            if (shape == MSG_NOISE && $urandom_range(0, 1))
                len = $urandom;
        end
        cut = (shape == MSG_CUT) ? $urandom_range(1, 8 + body.size()) : 8 + body.size();
        for (i = 0; i < cut; i++)
        begin
            if (i < 4)
                send_byte(len[31 - 8 * i -: 8], i == 0);
            else if (i < 8)
                send_byte(valid_b[i - 4], 1'b0);
            else
                send_byte(body[i - 8], 1'b0);
        end
    endtask

    // ---------------- tests
    task automatic test_directed;
        int i;
        // length past the default maximum
        send_byte(8'h00, 1'b1);
        send_byte(8'h20, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        // total wraps to zero: short message
        for (i = 0; i < 4; i++)
            send_byte(8'hFC | {8{i != 3}}, i == 0);
        for (i = 0; i < 4; i++)
            send_byte(NO_PATCH_BYTE, 1'b0);
        // ignored while idle
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        // one long matching unit, then a message with no patch
        send_msg(MSG_GOOD, 1'b1);
        send_msg(MSG_NOPATCH, 1'b0);
        drain();
    endtask

    task automatic test_random(input gap_t g, input int count);
        int   stop;
        msg_t shape;
        gap_mode = g;
        stop = n_items + count;
        while (n_items < stop)
        begin
            case ($urandom_range(0, 19))
                0, 1:  shape = MSG_NOPATCH;
                2:     shape = MSG_SHORT;
                3, 4:  shape = MSG_NOISE;
                5, 6:  shape = MSG_SKEW;
                7, 8:  shape = MSG_CUT;
                default: shape = MSG_GOOD;
            endcase
            send_msg(shape, 1'b0);
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3)) send_byte(rnd8(), 1'b0);
        end
        // finish on a complete message so the parser is idle for config writes
        send_msg(MSG_GOOD, 1'b0);
        drain();
    endtask

    task automatic test_backpressure;
        gap_mode = GAP_NONE;
        hold_req = 1'b1;
        send_msg(MSG_GOOD, 1'b1);
        send_msg(MSG_GOOD, 1'b1);
        drain();
    endtask

    // ---------------- result checker
    always @(posedge clk)
    begin
        word_t e;
        if (!rst_n)
            rch.ready <= 1'b0;
        else
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = HOLD_LEN;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rch.ready <= 1'b0;
            end
            else if (gap_mode == GAP_RECV)
                rch.ready <= ($urandom_range(0, 99) >= 58);
            else if (gap_mode == GAP_BOTH)
                rch.ready <= ($urandom_range(0, 99) >= 7);
            else
                rch.ready <= 1'b1;
            if (rch.valid && rch.ready)
            begin
                if (patch_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result kind=%0d pos=%0d val=%0h st=%0d", $time,
                             rch.kind, rch.position, rch.value, rch.status);
                end
                else
                begin
                    e = patch_q.pop_front();
                    if (rch.kind == KIND_WRITE)
                        n_writes++;
                    else
                        n_status++;
                    if (rch.kind !== e.kind || rch.position !== e.position ||
                        rch.value !== e.value || rch.status !== e.status)
                    begin
                        errors++;
                        $display("%0t: mismatch exp kind=%0d pos=%0d val=%0h st=%0d",
                                 $time, e.kind, e.position, e.value, e.status);
                        $display("%0t:          got kind=%0d pos=%0d val=%0h st=%0d",
                                 $time, rch.kind, rch.position, rch.value, rch.status);
                    end
                end
            end
        end
    end

    // watchdog: cycles without any word moving
    always @(posedge clk)
    begin
        if (rst_n && !((bch.valid && bch.ready) || (rch.valid && rch.ready)))
        begin
            idle_cnt++;
            if (idle_cnt >= IDLE_LIMIT)
            begin
                $display("timeout at %0t, %0d results outstanding", $time, patch_q.size());
                $display("testbench: errors");
                $finish;
            end
        end
        else
            idle_cnt = 0;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = '0;
        bch.valid = 1'b0;
        bch.data_byte = '0;
        bch.start_req = 1'b0;
        rch.ready = 1'b0;
        gap_mode = GAP_NONE;
        hold_req = 1'b0;
        hold_cnt = 0;
        errors = 0;
        n_items = 0;
        n_writes = 0;
        n_status = 0;
        idle_cnt = 0;
        app_id_r = 16'd0;
        max_len_r = 32'd2097152;
        ph = PH_IDLE;
        offs = 0;
        tlen = 0;
        ubase = 0;
        usize = 0;
        uid = 0;
        rfirst = 0;
        rlast = 0;
        hvalid = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_reg(REG_APP_ID, 32'h1234);
        test_random(GAP_NONE, 350);
        write_reg(REG_APP_ID, 32'hFFFF);
        write_reg(REG_MAX_LEN, 32'hFFFF_FFFF);
        test_random(GAP_SEND, 350);
        test_backpressure();
        write_reg(REG_APP_ID, 32'h0000);
        write_reg(REG_MAX_LEN, 32'h0000_0000);
        test_random(GAP_RECV, 100);
        write_reg(REG_APP_ID, 32'h8001);
        write_reg(REG_MAX_LEN, 32'd60);
        test_random(GAP_BOTH, 350);
        write_reg(REG_APP_ID, 32'($urandom_range(0, 65535)));
        write_reg(REG_MAX_LEN, 32'd2097152);
        test_random(GAP_RECV, 450);
        test_random(GAP_NONE, 300);

        repeat (20) @(posedge clk);
        $display("run: %0d bytes in, %0d patch writes and %0d status words checked",
                 n_items, n_writes, n_status);
        $display("run: six config settings, four idle patterns, one long result stall");
        if (errors == 0 && patch_q.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/mpcp_pkg.sv
rtl/mpcp_byte_if.sv
rtl/mpcp_result_if.sv
rtl/mpcp_front.sv
rtl/mpcp_queue.sv
rtl/mpcp_back.sv
rtl/masked_patch_command_parser.sv
rtl/mpcp_checker.sv
sim/testbench.sv
